// ===== src/pia_pkg.sv =====
`timescale 1ns / 1ps
// Package for the process ID allocator: default sizes, action and status
// codes and the sequencer state type. No dependencies.
package pia_pkg;

	// Default table depth and ID limit (IDs run from 1 to ID_LIMIT - 1)
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int ID_LIMIT_DEF    = 128;

	localparam int ACT_W    = 2;
	localparam int STATUS_W = 2;

	// Request kinds; the unused code is served as a lookup
	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_LOOKUP  = 2'd2
	} action_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_NOT_LIVE = 2'd2,
		STATUS_RANGE    = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIND,
		ST_FREE,
		ST_RESP
	} state_t;

endpackage

// ===== src/process_id_allocator_unit.sv =====
`timescale 1ns / 1ps
// Process ID allocator: one compare unit walks the ID table one entry per cycle.
// Lookup/release: bounded by the table walk through the single read port.
// Allocate: a walk of the valid bits to the lowest free slot, plus a full table pass
// of the free-ID scan for every pass in which the bound is reached.
// One transaction at a time; the result register lets a new request in while it waits.
// Reset clears valid bits, counters and handshake state; the ID memory is not cleared.
// Depends on pia_pkg.
module process_id_allocator_unit #(
	parameter int TABLE_DEPTH = pia_pkg::TABLE_DEPTH_DEF,
	parameter int ID_LIMIT    = pia_pkg::ID_LIMIT_DEF,
	parameter int PID_W       = $clog2(ID_LIMIT),
	parameter int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	parameter int IN_W        = ((PID_W + 7) / 8) * 8,
	parameter int OUT_W       = ((PID_W + SLOT_W + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [IN_W-1:0]              s_axis_tdata,  // [PID_W-1:0] pid, rest zero
	input  logic [pia_pkg::ACT_W-1:0]    s_axis_tuser,  // action
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [OUT_W-1:0]             m_axis_tdata,  // pid_out, then slot, rest zero
	output logic [pia_pkg::STATUS_W-1:0] m_axis_tuser   // status
);
	import pia_pkg::*;

	localparam int IDX_W    = $clog2(TABLE_DEPTH + 1);
	localparam int LI_W     = $clog2(ID_LIMIT + 1);
	localparam int LC_W     = $clog2(TABLE_DEPTH + 1);
	localparam int FULL_CNT = (TABLE_DEPTH < ID_LIMIT - 1) ? TABLE_DEPTH : ID_LIMIT - 1;

	// ID memory, read data registered
	logic [PID_W-1:0] id_mem [TABLE_DEPTH];
	logic [PID_W-1:0] rd_data_s1;
	logic             rd_en;
	logic             wr_en;

	// Control registers
	state_t             state_q, state_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic               vld_s1, vld_d;
	logic [SLOT_W-1:0]  eidx_s1, eidx_d;
	logic [LI_W-1:0]    last_q, last_d;
	logic [LI_W-1:0]    bound_q, bound_d;
	logic [LC_W-1:0]    live_q, live_d;
	logic [TABLE_DEPTH-1:0] valid_q, valid_d;
	logic               out_valid_q, out_valid_d;

	// Payload registers
	logic [PID_W-1:0]   key_q, key_d;
	logic               rel_q, rel_d;
	logic [PID_W-1:0]   res_pid_q, res_pid_d;
	logic [SLOT_W-1:0]  res_slot_q, res_slot_d;
	status_t            res_status_q, res_status_d;
	logic [PID_W-1:0]   out_pid_q;
	logic [SLOT_W-1:0]  out_slot_q;
	status_t            out_status_q;
	logic               out_load;

	// Datapath helpers
	logic               in_fire;
	logic [PID_W-1:0]   in_pid;
	logic [LI_W:0]      nxt_id;
	logic [LI_W-1:0]    inc_id;
	logic [LI_W-1:0]    entry_v;
	logic               entry_live;
	logic [SLOT_W-1:0]  idx_slot;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign in_pid        = s_axis_tdata[PID_W-1:0];
	assign idx_slot      = idx_q[SLOT_W-1:0];
	assign nxt_id        = {1'b0, last_q} + (LI_W + 1)'(1);
	assign inc_id        = last_q + LI_W'(1);
	assign entry_v       = LI_W'(rd_data_s1);
	assign entry_live    = vld_s1 && valid_q[eidx_s1];

	// Sequencer: next state and datapath updates
	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		vld_d        = 1'b0;
		eidx_d       = eidx_s1;
		last_d       = last_q;
		bound_d      = bound_q;
		live_d       = live_q;
		valid_d      = valid_q;
		key_d        = key_q;
		rel_d        = rel_q;
		res_pid_d    = res_pid_q;
		res_slot_d   = res_slot_q;
		res_status_d = res_status_q;
		rd_en        = 1'b0;
		wr_en        = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (s_axis_tuser == ACT_ALLOC) begin
						if (live_q >= LC_W'(FULL_CNT)) begin
							res_pid_d    = '0;
							res_slot_d   = '0;
							res_status_d = STATUS_FULL;
							state_d      = ST_RESP;
						end else if (nxt_id >= (LI_W + 1)'(ID_LIMIT)) begin
							// wrap to the first ID and rescan
							last_d  = LI_W'(1);
							bound_d = LI_W'(ID_LIMIT);
							idx_d   = '0;
							state_d = ST_SCAN;
						end else if (nxt_id >= {1'b0, bound_q}) begin
							last_d  = nxt_id[LI_W-1:0];
							bound_d = LI_W'(ID_LIMIT);
							idx_d   = '0;
							state_d = ST_SCAN;
						end else begin
							last_d  = nxt_id[LI_W-1:0];
							idx_d   = '0;
							state_d = ST_FREE;
						end
					end else if (in_pid == '0 || (LI_W'(in_pid) >= LI_W'(ID_LIMIT))) begin
						res_pid_d    = in_pid;
						res_slot_d   = '0;
						res_status_d = STATUS_RANGE;
						state_d      = ST_RESP;
					end else begin
						key_d   = in_pid;
						rel_d   = (s_axis_tuser == ACT_RELEASE);
						idx_d   = '0;
						state_d = ST_FIND;
					end
				end
			end
			ST_SCAN: begin
				// issue the next table read
				if (idx_q < IDX_W'(TABLE_DEPTH)) begin
					rd_en  = 1'b1;
					idx_d  = idx_q + IDX_W'(1);
					vld_d  = 1'b1;
					eidx_d = idx_slot;
				end
				if (entry_live && entry_v == last_q) begin
					// candidate taken: advance, restart the pass at the bound
					if (inc_id >= bound_q) begin
						last_d  = (inc_id >= LI_W'(ID_LIMIT)) ? LI_W'(1) : inc_id;
						bound_d = LI_W'(ID_LIMIT);
						idx_d   = '0;
						vld_d   = 1'b0;
						rd_en   = 1'b0;
					end else begin
						last_d = inc_id;
						if (eidx_s1 == SLOT_W'(TABLE_DEPTH - 1)) begin
							idx_d   = '0;
							state_d = ST_FREE;
						end
					end
				end else begin
					// narrow the bound to the smallest live ID above the candidate
					if (entry_live && entry_v > last_q && bound_q > entry_v) begin
						bound_d = entry_v;
					end
					if (vld_s1 && eidx_s1 == SLOT_W'(TABLE_DEPTH - 1)) begin
						idx_d   = '0;
						state_d = ST_FREE;
					end
				end
			end
			ST_FIND: begin
				if (idx_q < IDX_W'(TABLE_DEPTH)) begin
					rd_en  = 1'b1;
					idx_d  = idx_q + IDX_W'(1);
					vld_d  = 1'b1;
					eidx_d = idx_slot;
				end
				if (entry_live && rd_data_s1 == key_q) begin
					res_pid_d    = key_q;
					res_slot_d   = eidx_s1;
					res_status_d = STATUS_OK;
					if (rel_q) begin
						valid_d[eidx_s1] = 1'b0;
						if (live_q != '0) begin
							live_d = live_q - LC_W'(1);
						end
					end
					vld_d   = 1'b0;
					rd_en   = 1'b0;
					state_d = ST_RESP;
				end else if (vld_s1 && eidx_s1 == SLOT_W'(TABLE_DEPTH - 1)) begin
					res_pid_d    = key_q;
					res_slot_d   = '0;
					res_status_d = STATUS_NOT_LIVE;
					state_d      = ST_RESP;
				end
			end
			ST_FREE: begin
				// walk valid bits for the lowest free slot
				if (!valid_q[idx_slot]) begin
					wr_en             = 1'b1;
					valid_d[idx_slot] = 1'b1;
					live_d            = live_q + LC_W'(1);
					res_pid_d         = last_q[PID_W-1:0];
					res_slot_d        = idx_slot;
					res_status_d      = STATUS_OK;
					state_d           = ST_RESP;
				end else if (idx_q == IDX_W'(TABLE_DEPTH - 1)) begin
					res_pid_d    = '0;
					res_slot_d   = '0;
					res_status_d = STATUS_FULL;
					state_d      = ST_RESP;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			ST_RESP: begin
				// hand the result over once the output register is free
				if (!out_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (m_axis_tready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	// Hold the control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			last_q      <= LI_W'(ID_LIMIT);
			bound_q     <= LI_W'(ID_LIMIT);
			live_q      <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			vld_s1      <= vld_d;
			last_q      <= last_d;
			bound_q     <= bound_d;
			live_q      <= live_d;
			valid_q     <= valid_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Hold the payload
	always_ff @(posedge clk) begin
		eidx_s1      <= eidx_d;
		key_q        <= key_d;
		rel_q        <= rel_d;
		res_pid_q    <= res_pid_d;
		res_slot_q   <= res_slot_d;
		res_status_q <= res_status_d;
		if (out_load) begin
			out_pid_q    <= res_pid_q;
			out_slot_q   <= res_slot_q;
			out_status_q <= res_status_q;
		end
	end

	// ID memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[idx_slot] <= last_q[PID_W-1:0];
		end
		if (rd_en) begin
			rd_data_s1 <= id_mem[idx_slot];
		end
	end

	// Pack the result transaction
	always_comb begin
		m_axis_tdata                 = '0;
		m_axis_tdata[PID_W-1:0]      = out_pid_q;
		m_axis_tdata[PID_W+:SLOT_W]  = out_slot_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;

endmodule

// ===== verif/tb_process_id_allocator_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for process_id_allocator_unit: sends allocate, release and
// lookup transactions with random gaps and stalls, predicts each result locally.
// Depends on pia_pkg and process_id_allocator_unit.
module tb_process_id_allocator_unit;
	import pia_pkg::*;

	localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
	localparam int ID_LIMIT    = ID_LIMIT_DEF;
	localparam int PID_W       = $clog2(ID_LIMIT);
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int IN_W        = ((PID_W + 7) / 8) * 8;
	localparam int OUT_W       = ((PID_W + SLOT_W + 7) / 8) * 8;

	// Unused action code, served by the block as a lookup
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

	localparam int RANDOM_ITEMS = 1450;
	localparam int IDLE_LIMIT   = 50000;
	localparam int TAIL_CYCLES  = 4 * (TABLE_DEPTH + 2);

	// Episode flavors of the random traffic
	localparam int EP_FILL  = 0;
	localparam int EP_DRAIN = 1;
	localparam int EP_MIX   = 2;

	typedef struct packed {
		logic [PID_W-1:0]  pid;
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} pid_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata = '0;   // [6:0] pid, rest zero
	logic [ACT_W-1:0]    s_axis_tuser = ACT_LOOKUP;  // action
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_W-1:0]    m_axis_tdata;   // [6:0] pid_out, [12:7] slot, rest zero
	logic [STATUS_W-1:0] m_axis_tuser;   // status

	// Allocator state as predicted from the accepted requests
	logic [PID_W-1:0] pid_table [TABLE_DEPTH];
	bit               pid_live [TABLE_DEPTH];
	int               cand_pid = ID_LIMIT;
	int               bound_pid = ID_LIMIT;
	int               live_total = 0;

	pid_result_t pending_results[$];
	int          mismatch_count = 0;
	int          sent_total = 0;
	int          status_count [4] = '{0, 0, 0, 0};
	int          gap_max = 14;
	int          stall_max = 14;
	int          idle_cycles = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	process_id_allocator_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	function automatic int find_live_slot(input logic [PID_W-1:0] id);
		int s;
		s = -1;
		for (int i = 0; i < TABLE_DEPTH && s < 0; i++)
			if (pid_live[i] && pid_table[i] == id)
				s = i;
		return s;
	endfunction

	// Walk the table until the candidate ID is free; restart whenever it meets the bound
	function automatic void rescan_free_ids();
		bit again;
		bound_pid = ID_LIMIT;
		again = 1'b1;
		while (again) begin
			again = 1'b0;
			for (int i = 0; i < TABLE_DEPTH && !again; i++) begin
				if (pid_live[i]) begin
					if (pid_table[i] == cand_pid) begin
						cand_pid++;
						if (cand_pid >= bound_pid) begin
							if (cand_pid >= ID_LIMIT)
								cand_pid = 1;
							bound_pid = ID_LIMIT;
							again = 1'b1;
						end
					end else if (pid_table[i] > cand_pid && bound_pid > pid_table[i]) begin
						bound_pid = pid_table[i];
					end
				end
			end
		end
	endfunction

	// Advance the allocator state by one request and return the result it causes
	function automatic pid_result_t predict_pid_op(input logic [ACT_W-1:0] act,
			input logic [PID_W-1:0] id);
		pid_result_t res;
		int s;
		res.pid = id;
		res.slot = '0;
		res.status = STATUS_OK;
		if (act == ACT_ALLOC) begin
			res.pid = '0;
			if (live_total >= TABLE_DEPTH || live_total >= ID_LIMIT - 1) begin
				res.status = STATUS_FULL;
				return res;
			end
			cand_pid++;
			if (cand_pid >= ID_LIMIT) begin
				cand_pid = 1;
				rescan_free_ids();
			end else if (cand_pid >= bound_pid) begin
				rescan_free_ids();
			end
			s = -1;
			for (int i = 0; i < TABLE_DEPTH && s < 0; i++)
				if (!pid_live[i])
					s = i;
			if (s < 0) begin
				res.status = STATUS_FULL;
				return res;
			end
			pid_table[s] = PID_W'(cand_pid);
			pid_live[s] = 1'b1;
			live_total++;
			res.pid = PID_W'(cand_pid);
			res.slot = SLOT_W'(s);
			return res;
		end
		if (id == 0 || int'(id) >= ID_LIMIT) begin
			res.status = STATUS_RANGE;
			return res;
		end
		s = find_live_slot(id);
		if (s < 0) begin
			res.status = STATUS_NOT_LIVE;
			return res;
		end
		if (act == ACT_RELEASE) begin
			pid_live[s] = 1'b0;
			live_total--;
		end
		res.slot = SLOT_W'(s);
		return res;
	endfunction

	// Random ID currently held in the table; call only with live_total > 0
	function automatic logic [PID_W-1:0] pick_live_pid();
		int start;
		int idx;
		start = $urandom_range(0, TABLE_DEPTH - 1);
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			idx = (start + k) % TABLE_DEPTH;
			if (pid_live[idx])
				return pid_table[idx];
		end
		return '0;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Send one request; valid stays high into the next call when no gap is drawn
	task automatic issue_request(input logic [ACT_W-1:0] act, input logic [PID_W-1:0] id);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_W'(id);
		s_axis_tuser <= act;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(predict_pid_op(act, id));
		sent_total++;
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Out-of-range and not-live requests on an empty table, with the lookup, release and spare action codes
	task automatic test_empty_table();
		issue_request(ACT_LOOKUP, 7'd0);
		issue_request(ACT_RELEASE, 7'd0);
		issue_request(ACT_LOOKUP, 7'd127);
		issue_request(ACT_RELEASE, 7'd85);
		issue_request(ACT_SPARE, 7'd42);
		issue_request(ACT_SPARE, 7'd0);
		drain_results();
	endtask

	// First allocations after the reset wrap, release, reuse of the lowest slot
	task automatic test_alloc_release();
		repeat (4) issue_request(ACT_ALLOC, 7'd0);
		issue_request(ACT_LOOKUP, 7'd3);
		issue_request(ACT_SPARE, 7'd2);
		issue_request(ACT_RELEASE, 7'd2);
		issue_request(ACT_LOOKUP, 7'd2);
		issue_request(ACT_RELEASE, 7'd2);
		issue_request(ACT_ALLOC, 7'd127);
		issue_request(ACT_LOOKUP, 7'd5);
		issue_request(ACT_RELEASE, 7'd1);
		issue_request(ACT_ALLOC, 7'd85);
		issue_request(ACT_RELEASE, 7'd127);
		drain_results();
	endtask

	// Episodes that fill, drain or mix the table, so that full refusals and
	// ID wrap scans over a crowded table come up many times
	task automatic test_random_traffic();
		int done_items;
		int kind;
		int span;
		int alloc_pct;
		int pick;
		logic [ACT_W-1:0] act;
		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			kind = $urandom_range(EP_FILL, EP_MIX);
			span = $urandom_range(20, 90);
			if (span > RANDOM_ITEMS - done_items)
				span = RANDOM_ITEMS - done_items;
			gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
			stall_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
			alloc_pct = (kind == EP_FILL) ? 80 : (kind == EP_DRAIN) ? 15 : 45;
			repeat (span) begin
				pick = $urandom_range(0, 99);
				if (pick < alloc_pct) begin
					issue_request(ACT_ALLOC, PID_W'($urandom));
				end else begin
					pick = $urandom_range(0, 9);
					if (pick < 5 && live_total > 0) begin
						issue_request(ACT_RELEASE, pick_live_pid());
					end else if (pick < 7 && live_total > 0) begin
						act = $urandom_range(0, 1) ? ACT_LOOKUP : ACT_SPARE;
						issue_request(act, pick_live_pid());
					end else begin
						pick = $urandom_range(0, 2);
						act = (pick == 0) ? ACT_RELEASE : (pick == 1) ? ACT_LOOKUP : ACT_SPARE;
						issue_request(act, PID_W'($urandom));
					end
				end
				done_items++;
			end
		end
		gap_max = 14;
		stall_max = 14;
	endtask

	// Accept results with random stalls and compare against the oldest prediction
	initial begin : result_checker
		int stall;
		pid_result_t got;
		pid_result_t want;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.pid = m_axis_tdata[PID_W-1:0];
				got.slot = m_axis_tdata[PID_W+SLOT_W-1:PID_W];
				got.status = status_t'(m_axis_tuser);
				status_count[m_axis_tuser]++;
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing expected, actual pid %0d slot %0d status %0d",
						$time, got.pid, got.slot, got.status);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("pid_out", want.pid, got.pid);
					check_field("slot", want.slot, got.slot);
					check_field("status", want.status, got.status);
				end
				stall = $urandom_range(0, stall_max);
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, idle_cycles, pending_results.size());
				$display("process_id_allocator_unit test failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_alloc_release();
		test_random_traffic();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d requests; results: %0d ok, %0d table full, %0d not live, %0d out of range.",
			sent_total, status_count[STATUS_OK], status_count[STATUS_FULL],
			status_count[STATUS_NOT_LIVE], status_count[STATUS_RANGE]);
		$display("Mismatches found: %0d", mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("process_id_allocator_unit test passed");
		end else begin
			$display("process_id_allocator_unit test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/pia_pkg.sv
src/process_id_allocator_unit.sv
verif/tb_process_id_allocator_unit.sv
